/* hdl/assert_macros.svh */
// Assertion macros used by the frame stack bin average core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check on clk, switched off while rst is high.
`define FSBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Concurrent check on clk that also holds through reset.
`define FSBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSBA_ASSERT(lbl, prop, msg)
`define FSBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/fsba_pkg.sv */
// Constants shared by the frame stack bin average block.
package fsba_pkg;

  // Geometry and sample width.
  localparam int MAX_TARGET_WIDTH  = 256;
  localparam int MAX_TARGET_HEIGHT = 256;
  localparam int SAMPLE_BITS       = 16;

  // Accumulator memory.
  localparam int SUM_DEPTH  = MAX_TARGET_WIDTH * MAX_TARGET_HEIGHT;
  localparam int ADDR_W     = $clog2(SUM_DEPTH);
  localparam int SUM_W      = 32;
  localparam int TX_W       = $clog2(MAX_TARGET_WIDTH);
  localparam int TY_W       = $clog2(MAX_TARGET_HEIGHT);

  // Register field widths and clamp limits.
  localparam int BS_W  = 5;
  localparam int FC_W  = 7;
  localparam int TW_W  = 9;
  localparam int TH_W  = 9;
  localparam int BS_MAX = 16;
  localparam int FC_MAX = 64;
  localparam int XO_W   = $clog2(BS_MAX);
  localparam int FI_W   = $clog2(FC_MAX);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BIN_SIZE      = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT   = 2'd1;
  localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

  // Divider: divisor up to 16*16*64, dividend is sum*256 plus half the divisor.
  localparam int DIV_W     = 15;
  localparam int DVD_W     = SUM_W + 9;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int MEAN_W    = 24;

endpackage

/* hdl/frame_stack_bin_average_core.sv */
// Top level of the frame stack bin average block: counters, accumulator RAM, divider.
//
//   channel   dir  signals                         meaning
//   s_*       in   s_tvalid s_tready s_tdata       one stack sample per transaction
//   m_*       out  m_tvalid m_tready m_tdata m_tlast  one bin mean per transaction
//   apb       in   psel penable pwrite paddr pwdata prdata pready  configuration
//
// A sample's accumulator is read from the RAM on accept; ST_MODIFY adds the sample and
// writes it back. The last sample of a target pixel then passes ST_ROUND (rounding),
// ST_DIV (restoring divider, one quotient bit per cycle) and ST_HOLD, which loads the
// output register. No RAM clearing pass: a pixel's first sample overwrites its entry.
// Reset clears the counters, the state and the output valid and loads register
// defaults. A held output stalls the block only when the next mean is ready.
module frame_stack_bin_average_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [23:0] mean_value, [31:24] out_col, [39:32] out_row
  output logic        m_tlast,   // image_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MODIFY = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;

  logic [2:0] state;

  // Configuration registers, raw and clamped.
  logic [fsba_pkg::BS_W-1:0] bin_size;
  logic [fsba_pkg::FC_W-1:0] frame_count;
  logic [fsba_pkg::TW_W-1:0] target_width;
  logic [fsba_pkg::TH_W-1:0] target_height;
  logic [fsba_pkg::BS_W-1:0] bs_c;
  logic [fsba_pkg::FC_W-1:0] fc_c;
  logic [fsba_pkg::TW_W-1:0] tw_c;
  logic [fsba_pkg::TH_W-1:0] th_c;
  logic [fsba_pkg::XO_W-1:0] bs_m1;
  logic [fsba_pkg::FI_W-1:0] fc_m1;
  logic [fsba_pkg::TX_W-1:0] tw_m1;
  logic [fsba_pkg::TY_W-1:0] th_m1;
  logic                      cfg_wr;

  // Stack position counters.
  logic [fsba_pkg::XO_W-1:0]   xo;
  logic [fsba_pkg::XO_W-1:0]   yo;
  logic [fsba_pkg::TX_W-1:0]   tx;
  logic [fsba_pkg::TY_W-1:0]   ty;
  logic [fsba_pkg::FI_W-1:0]   frame_index;
  logic [fsba_pkg::ADDR_W-1:0] row_base;

  // Captured item.
  logic                          accept;
  logic                          first_px;
  logic                          last_px;
  logic                          done_px;
  logic [fsba_pkg::ADDR_W-1:0]   cur_idx;
  logic [fsba_pkg::ADDR_W-1:0]   idx_q;
  logic [fsba_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                          first_q;
  logic                          last_q;
  logic                          done_q;
  logic [fsba_pkg::TX_W-1:0]     col_q;
  logic [fsba_pkg::TY_W-1:0]     row_q;

  // Accumulator RAM.
  logic [fsba_pkg::SUM_W-1:0] pixel_sums [fsba_pkg::SUM_DEPTH];
  logic [fsba_pkg::SUM_W-1:0] rdata;
  logic [fsba_pkg::SUM_W-1:0] new_sum;
  logic [fsba_pkg::SUM_W-1:0] sum_q;

  // Divider.
  logic [8:0]                 bs_sq;
  logic [fsba_pkg::DIV_W-1:0] div_d;
  logic [fsba_pkg::DVD_W-1:0] quo;
  logic [fsba_pkg::DIV_W-1:0] rem;
  logic [fsba_pkg::DIV_W:0]   trial;
  logic [fsba_pkg::DIV_W:0]   trial_diff;
  logic [fsba_pkg::CNT_W-1:0] div_cnt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_size      <= fsba_pkg::BS_W'(1);
      frame_count   <= fsba_pkg::FC_W'(1);
      target_width  <= fsba_pkg::TW_W'(256);
      target_height <= fsba_pkg::TH_W'(256);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fsba_pkg::REG_BIN_SIZE:      bin_size      <= pwdata[fsba_pkg::BS_W-1:0];
        fsba_pkg::REG_FRAME_COUNT:   frame_count   <= pwdata[fsba_pkg::FC_W-1:0];
        fsba_pkg::REG_TARGET_WIDTH:  target_width  <= pwdata[fsba_pkg::TW_W-1:0];
        fsba_pkg::REG_TARGET_HEIGHT: target_height <= pwdata[fsba_pkg::TH_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      fsba_pkg::REG_BIN_SIZE:      prdata = 32'(bin_size);
      fsba_pkg::REG_FRAME_COUNT:   prdata = 32'(frame_count);
      fsba_pkg::REG_TARGET_WIDTH:  prdata = 32'(target_width);
      fsba_pkg::REG_TARGET_HEIGHT: prdata = 32'(target_height);
      default:                     prdata = '0;
    endcase
  end

  // Clamp register values to their legal ranges.
  always_comb begin
    if (bin_size == '0)                            bs_c = fsba_pkg::BS_W'(1);
    else if (bin_size > fsba_pkg::BS_W'(fsba_pkg::BS_MAX)) bs_c = fsba_pkg::BS_W'(fsba_pkg::BS_MAX);
    else                                           bs_c = bin_size;
    if (frame_count == '0)                         fc_c = fsba_pkg::FC_W'(1);
    else if (frame_count > fsba_pkg::FC_W'(fsba_pkg::FC_MAX)) fc_c = fsba_pkg::FC_W'(fsba_pkg::FC_MAX);
    else                                           fc_c = frame_count;
    if (target_width == '0)                        tw_c = fsba_pkg::TW_W'(1);
    else if (target_width > fsba_pkg::TW_W'(fsba_pkg::MAX_TARGET_WIDTH))
      tw_c = fsba_pkg::TW_W'(fsba_pkg::MAX_TARGET_WIDTH);
    else                                           tw_c = target_width;
    if (target_height == '0)                       th_c = fsba_pkg::TH_W'(1);
    else if (target_height > fsba_pkg::TH_W'(fsba_pkg::MAX_TARGET_HEIGHT))
      th_c = fsba_pkg::TH_W'(fsba_pkg::MAX_TARGET_HEIGHT);
    else                                           th_c = target_height;
  end

  assign bs_m1 = fsba_pkg::XO_W'(bs_c - fsba_pkg::BS_W'(1));
  assign fc_m1 = fsba_pkg::FI_W'(fc_c - fsba_pkg::FC_W'(1));
  assign tw_m1 = fsba_pkg::TX_W'(tw_c - fsba_pkg::TW_W'(1));
  assign th_m1 = fsba_pkg::TY_W'(th_c - fsba_pkg::TH_W'(1));

  // Divisor bin_size^2 * frame_count, two registered multiplies.
  always_ff @(posedge clk) begin
    bs_sq <= 9'(bs_c) * 9'(bs_c);
    div_d <= fsba_pkg::DIV_W'(bs_sq) * fsba_pkg::DIV_W'(fc_c);
  end

  // Pixel classification at the current stack position.
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign cur_idx  = row_base + fsba_pkg::ADDR_W'(tx);
  assign first_px = (frame_index == '0) && (xo == '0) && (yo == '0);
  assign last_px  = (frame_index == fc_m1) && (xo == bs_m1) && (yo == bs_m1);
  assign done_px  = (tx == tw_m1) && (ty == th_m1);

  // Advance the stack position; any register write restarts the stack.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      xo          <= '0;
      yo          <= '0;
      tx          <= '0;
      ty          <= '0;
      frame_index <= '0;
      row_base    <= '0;
    end else if (accept) begin
      if (xo != bs_m1) begin
        xo <= xo + 1'b1;
      end else begin
        xo <= '0;
        if (tx != tw_m1) begin
          tx <= tx + 1'b1;
        end else begin
          tx <= '0;
          if (yo != bs_m1) begin
            yo <= yo + 1'b1;
          end else begin
            yo <= '0;
            if (ty != th_m1) begin
              ty       <= ty + 1'b1;
              row_base <= row_base + fsba_pkg::ADDR_W'(tw_c);
            end else begin
              ty       <= '0;
              row_base <= '0;
              if (frame_index != fc_m1) frame_index <= frame_index + 1'b1;
              else                      frame_index <= '0;
            end
          end
        end
      end
    end
  end

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q    <= cur_idx;
      sample_q <= s_tdata[fsba_pkg::SAMPLE_BITS-1:0];
      first_q  <= first_px;
      last_q   <= last_px;
      done_q   <= done_px;
      col_q    <= tx;
      row_q    <= ty;
    end
  end

  // Accumulator RAM: read on accept, write back in the following cycle (ST_MODIFY).
  assign new_sum = first_q ? fsba_pkg::SUM_W'(sample_q)
                           : rdata + fsba_pkg::SUM_W'(sample_q);

  always_ff @(posedge clk) begin
    if (accept) rdata <= pixel_sums[cur_idx];
    if (state == ST_MODIFY) pixel_sums[idx_q] <= new_sum;
  end

  always_ff @(posedge clk) begin
    if (state == ST_MODIFY) sum_q <= new_sum;
  end

  // Restoring divider step.
  assign trial      = {rem, quo[fsba_pkg::DVD_W-1]};
  assign trial_diff = trial - {1'b0, div_d};

  always_ff @(posedge clk) begin
    case (state)
      ST_ROUND: begin
        quo     <= {sum_q, 8'h00} + fsba_pkg::DVD_W'(div_d >> 1);
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        if (!trial_diff[fsba_pkg::DIV_W]) begin
          rem <= trial_diff[fsba_pkg::DIV_W-1:0];
          quo <= {quo[fsba_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[fsba_pkg::DIV_W-1:0];
          quo <= {quo[fsba_pkg::DVD_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:   if (accept) state <= ST_MODIFY;
        ST_MODIFY: state <= last_q ? ST_ROUND : ST_IDLE;
        ST_ROUND:  state <= ST_DIV;
        ST_DIV:    if (div_cnt == fsba_pkg::CNT_W'(fsba_pkg::DIV_STEPS - 1)) state <= ST_HOLD;
        ST_HOLD:   if (!m_tvalid || m_tready) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_HOLD && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && (!m_tvalid || m_tready)) begin
      m_tdata <= {row_q, col_q, quo[fsba_pkg::MEAN_W-1:0]};
      m_tlast <= done_q;
    end
  end

  // Checks.
  `FSBA_ASSERT(a_accept_to_modify, accept |=> (state == ST_MODIFY), "accepted sample not written back")
  `FSBA_ASSERT(a_rem_bound, (state == ST_DIV) |-> (rem < div_d), "divider remainder out of range")
  `FSBA_ASSERT(a_pos_bound, (5'(xo) < bs_c) && (9'(tx) < tw_c), "stack position outside the frame")

endmodule
